// ===== hdl/hce_pkg.sv =====
// Shared types, codes and mnemonic tables for the Hack C-instruction encoder.
`timescale 1ns / 1ps

package hce_pkg;

   // Default number of characters that one field text can hold.
   localparam int FIELD_CHARS_DEFAULT = 3;

   // Parse phases: before any delimiter, after '=', after ';', error seen.
   localparam logic [1:0] PHASE_FIRST = 2'd0;
   localparam logic [1:0] PHASE_COMP  = 2'd1;
   localparam logic [1:0] PHASE_JUMP  = 2'd2;
   localparam logic [1:0] PHASE_ERR   = 2'd3;

   // Result status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_COMP = 2'd1;
   localparam logic [1:0] STATUS_BAD_DJ   = 2'd2;
   localparam logic [1:0] STATUS_SYNTAX   = 2'd3;

   // Delimiter characters.
   localparam logic [7:0] CHAR_EQUALS = 8'h3D;
   localparam logic [7:0] CHAR_SEMI   = 8'h3B;

   // One input item and one result item.
   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [15:0] word;
      logic [1:0]  status;
   } rsp_type;

   // A field reduced to a lookup key: length of up to three and three
   // characters, the ones beyond the length forced to zero.
   typedef struct packed {
      logic        fits;
      logic [1:0]  len;
      logic [23:0] chars;
   } key_type;

   // Field view after the current character, handed from parser to encoder.
   typedef struct packed {
      logic [1:0] phase;
      key_type    first_key;
      key_type    comp_key;
      key_type    jump_key;
   } fields_type;

   // Build a key from the first three characters of a field.
   function automatic key_type make_key(input logic [7:0] c0,
                                        input logic [7:0] c1,
                                        input logic [7:0] c2,
                                        input logic [1:0] n,
                                        input logic       fits);
      key_type k;
      k.fits  = fits;
      k.len   = n;
      k.chars = {(n >= 2'd1) ? c0 : 8'h00,
                 (n >= 2'd2) ? c1 : 8'h00,
                 (n == 2'd3) ? c2 : 8'h00};
      return k;
   endfunction

   // Comp table: returns {hit, code}.
   function automatic logic [7:0] comp_lookup(input key_type k);
      logic [7:0] r;
      r = 8'h00;
      if (k.fits) begin
         case ({k.len, k.chars})
            {2'd1, "0", 16'h0000}: r = {1'b1, 7'h2A};
            {2'd1, "1", 16'h0000}: r = {1'b1, 7'h3F};
            {2'd2, "-1", 8'h00}:   r = {1'b1, 7'h3A};
            {2'd1, "D", 16'h0000}: r = {1'b1, 7'h0C};
            {2'd1, "A", 16'h0000}: r = {1'b1, 7'h30};
            {2'd2, "!D", 8'h00}:   r = {1'b1, 7'h0D};
            {2'd2, "!A", 8'h00}:   r = {1'b1, 7'h31};
            {2'd2, "-D", 8'h00}:   r = {1'b1, 7'h0F};
            {2'd2, "-A", 8'h00}:   r = {1'b1, 7'h33};
            {2'd3, "D+1"}:         r = {1'b1, 7'h1F};
            {2'd3, "A+1"}:         r = {1'b1, 7'h37};
            {2'd3, "D-1"}:         r = {1'b1, 7'h0E};
            {2'd3, "A-1"}:         r = {1'b1, 7'h32};
            {2'd3, "D+A"}:         r = {1'b1, 7'h02};
            {2'd3, "D-A"}:         r = {1'b1, 7'h13};
            {2'd3, "A-D"}:         r = {1'b1, 7'h07};
            {2'd3, "D&A"}:         r = {1'b1, 7'h00};
            {2'd3, "D|A"}:         r = {1'b1, 7'h15};
            {2'd1, "M", 16'h0000}: r = {1'b1, 7'h70};
            {2'd2, "!M", 8'h00}:   r = {1'b1, 7'h71};
            {2'd2, "-M", 8'h00}:   r = {1'b1, 7'h73};
            {2'd3, "M+1"}:         r = {1'b1, 7'h77};
            {2'd3, "M-1"}:         r = {1'b1, 7'h72};
            {2'd3, "D+M"}:         r = {1'b1, 7'h42};
            {2'd3, "D-M"}:         r = {1'b1, 7'h53};
            {2'd3, "M-D"}:         r = {1'b1, 7'h47};
            {2'd3, "D&M"}:         r = {1'b1, 7'h40};
            {2'd3, "D|M"}:         r = {1'b1, 7'h55};
            default:               r = 8'h00;
         endcase
      end
      return r;
   endfunction

   // Dest table: returns {hit, code}.
   function automatic logic [3:0] dest_lookup(input key_type k);
      logic [3:0] r;
      r = 4'h0;
      if (k.fits) begin
         case ({k.len, k.chars})
            {2'd0, 24'h000000}:     r = {1'b1, 3'd0};
            {2'd1, "M", 16'h0000}:  r = {1'b1, 3'd1};
            {2'd1, "D", 16'h0000}:  r = {1'b1, 3'd2};
            {2'd2, "MD", 8'h00}:    r = {1'b1, 3'd3};
            {2'd1, "A", 16'h0000}:  r = {1'b1, 3'd4};
            {2'd2, "AM", 8'h00}:    r = {1'b1, 3'd5};
            {2'd2, "AD", 8'h00}:    r = {1'b1, 3'd6};
            {2'd3, "AMD"}:          r = {1'b1, 3'd7};
            default:                r = 4'h0;
         endcase
      end
      return r;
   endfunction

   // Jump table: returns {hit, code}.
   function automatic logic [3:0] jump_lookup(input key_type k);
      logic [3:0] r;
      r = 4'h0;
      if (k.fits) begin
         case ({k.len, k.chars})
            {2'd0, 24'h000000}: r = {1'b1, 3'd0};
            {2'd3, "JGT"}:      r = {1'b1, 3'd1};
            {2'd3, "JEQ"}:      r = {1'b1, 3'd2};
            {2'd3, "JGE"}:      r = {1'b1, 3'd3};
            {2'd3, "JLT"}:      r = {1'b1, 3'd4};
            {2'd3, "JNE"}:      r = {1'b1, 3'd5};
            {2'd3, "JLE"}:      r = {1'b1, 3'd6};
            {2'd3, "JMP"}:      r = {1'b1, 3'd7};
            default:            r = 4'h0;
         endcase
      end
      return r;
   endfunction

endpackage

// ===== hdl/hce_parser.sv =====
// Parse state: field texts, lengths and delimiter phase of one instruction.
`timescale 1ns / 1ps

module hce_parser #(
   parameter int FIELD_CHARS = hce_pkg::FIELD_CHARS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  hce_pkg::req_type    item,
   output hce_pkg::fields_type fields
);
   import hce_pkg::*;

   localparam int LW = $clog2(FIELD_CHARS + 1);

   // The dest text is always the first text while its length is kept in
   // first_len, so no separate dest copy is stored.
   logic [1:0]    phase_ff, phase_in;
   logic [LW-1:0] first_len_ff, first_len_in;
   logic [LW-1:0] comp_len_ff, comp_len_in;
   logic [LW-1:0] jump_len_ff, jump_len_in;
   logic [7:0]    first_text_ff [FIELD_CHARS];
   logic [7:0]    first_text_in [FIELD_CHARS];
   logic [7:0]    comp_text_ff  [FIELD_CHARS];
   logic [7:0]    comp_text_in  [FIELD_CHARS];
   logic [7:0]    jump_text_ff  [FIELD_CHARS];
   logic [7:0]    jump_text_in  [FIELD_CHARS];

   // Apply the current character to the parse state.
   always_comb begin
      phase_in     = phase_ff;
      first_len_in = first_len_ff;
      comp_len_in  = comp_len_ff;
      jump_len_in  = jump_len_ff;
      first_text_in = first_text_ff;
      comp_text_in  = comp_text_ff;
      jump_text_in  = jump_text_ff;
      if (phase_ff != PHASE_ERR) begin
         if (item.character == CHAR_EQUALS) begin
            phase_in = (phase_ff == PHASE_FIRST) ? PHASE_COMP : PHASE_ERR;
         end else if (item.character == CHAR_SEMI) begin
            case (phase_ff)
               PHASE_FIRST: begin
                  // Semicolon first: the first text is the comp, dest empty.
                  comp_text_in = first_text_ff;
                  comp_len_in  = first_len_ff;
                  first_len_in = '0;
                  phase_in     = PHASE_JUMP;
               end
               PHASE_COMP: begin
                  phase_in = PHASE_JUMP;
               end
               default: begin
                  phase_in = PHASE_ERR;
               end
            endcase
         end else begin
            case (phase_ff)
               PHASE_FIRST: begin
                  if (first_len_ff >= LW'(FIELD_CHARS)) begin
                     phase_in = PHASE_ERR;
                  end else begin
                     for (int i = 0; i < FIELD_CHARS; i++) begin
                        if (first_len_ff == LW'(i)) begin
                           first_text_in[i] = item.character;
                        end
                     end
                     first_len_in = first_len_ff + LW'(1);
                  end
               end
               PHASE_COMP: begin
                  if (comp_len_ff >= LW'(FIELD_CHARS)) begin
                     phase_in = PHASE_ERR;
                  end else begin
                     for (int i = 0; i < FIELD_CHARS; i++) begin
                        if (comp_len_ff == LW'(i)) begin
                           comp_text_in[i] = item.character;
                        end
                     end
                     comp_len_in = comp_len_ff + LW'(1);
                  end
               end
               default: begin
                  if (jump_len_ff >= LW'(FIELD_CHARS)) begin
                     phase_in = PHASE_ERR;
                  end else begin
                     for (int i = 0; i < FIELD_CHARS; i++) begin
                        if (jump_len_ff == LW'(i)) begin
                           jump_text_in[i] = item.character;
                        end
                     end
                     jump_len_in = jump_len_ff + LW'(1);
                  end
               end
            endcase
         end
      end
   end

   // Field keys as they stand after this character.
   always_comb begin
      fields.phase     = phase_in;
      fields.first_key = make_key(first_text_in[0], first_text_in[1], first_text_in[2],
                                  first_len_in[1:0], first_len_in <= LW'(3));
      fields.comp_key  = make_key(comp_text_in[0], comp_text_in[1], comp_text_in[2],
                                  comp_len_in[1:0], comp_len_in <= LW'(3));
      fields.jump_key  = make_key(jump_text_in[0], jump_text_in[1], jump_text_in[2],
                                  jump_len_in[1:0], jump_len_in <= LW'(3));
   end

   // Phase and lengths return to zero after the last character.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_FIRST;
         first_len_ff <= '0;
         comp_len_ff  <= '0;
         jump_len_ff  <= '0;
      end else if (step) begin
         if (item.last) begin
            phase_ff     <= PHASE_FIRST;
            first_len_ff <= '0;
            comp_len_ff  <= '0;
            jump_len_ff  <= '0;
         end else begin
            phase_ff     <= phase_in;
            first_len_ff <= first_len_in;
            comp_len_ff  <= comp_len_in;
            jump_len_ff  <= jump_len_in;
         end
      end
   end

   // Text beyond a field's length is never looked at, so texts need no reset.
   always_ff @(posedge clock) begin
      if (step) begin
         first_text_ff <= first_text_in;
         comp_text_ff  <= comp_text_in;
         jump_text_ff  <= jump_text_in;
      end
   end

endmodule

// ===== hdl/hce_encode.sv =====
// Mnemonic matching and assembly of the 16-bit word and its status.
`timescale 1ns / 1ps

module hce_encode (
   input  hce_pkg::fields_type fields,
   output hce_pkg::rsp_type    result
);
   import hce_pkg::*;

   logic [7:0] comp_hit;
   logic [3:0] dest_hit;
   logic [3:0] jump_hit;

   // Select which key feeds each table for the current phase.
   always_comb begin
      if (fields.phase == PHASE_FIRST) begin
         comp_hit = comp_lookup(fields.first_key);
         dest_hit = {1'b1, 3'd0};
      end else begin
         comp_hit = comp_lookup(fields.comp_key);
         dest_hit = dest_lookup(fields.first_key);
      end
      jump_hit = (fields.phase == PHASE_JUMP) ? jump_lookup(fields.jump_key)
                                               : {1'b1, 3'd0};
   end

   // Syntax errors win over an unknown comp, which wins over dest or jump.
   always_comb begin
      result.word = 16'h0000;
      if (fields.phase == PHASE_ERR) begin
         result.status = STATUS_SYNTAX;
      end else if (!comp_hit[7]) begin
         result.status = STATUS_BAD_COMP;
      end else if (!dest_hit[3] || !jump_hit[3]) begin
         result.status = STATUS_BAD_DJ;
      end else begin
         result.status = STATUS_OK;
         result.word   = {3'b111, comp_hit[6:0], dest_hit[2:0], jump_hit[2:0]};
      end
   end

endmodule

// ===== hdl/hack_c_instruction_encoder_core.sv =====
// Top level of the Hack C-instruction encoder: input stage, parser, encoder, result register.
`timescale 1ns / 1ps

// Usage:
// - req channel: one ASCII character of a C-instruction "dest=comp;jump" per
//   item, with last set on the final character. No result for other items.
// - rsp channel: one item per instruction carrying the 16-bit word
//   (111 comp dest jump) and a status; the word is zero unless status is ok.
// - Each character is held in an input register and applied to the parse
//   state, and on a last character the matched result is captured in the
//   output register. An accepted last character passes the input register
//   and then the output register on its way to rsp_valid.
// - Throughput is one character per cycle while req_stall is low; the parse
//   state takes each character in a single combinational update.
// - When rsp_stall holds a result, characters that are not last keep flowing;
//   a last character waits in the input stage and req_stall rises until the
//   held result is taken.
// - Synchronous reset empties both stages and returns the parser to the
//   start of an instruction.
module hack_c_instruction_encoder_core #(
   parameter int FIELD_CHARS = hce_pkg::FIELD_CHARS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hce_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hce_pkg::rsp_type rsp_data
);
   import hce_pkg::*;

   logic       in_valid_ff, in_valid_in;
   req_type    in_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff;
   logic       advance;
   fields_type fields;
   rsp_type    result;

   // The held item moves on unless it is a last character blocked by a
   // stalled result.
   assign advance   = in_valid_ff && !(in_ff.last && rsp_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // Input stage.
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_data;
      end
   end

   hce_parser #(
      .FIELD_CHARS(FIELD_CHARS)
   ) u_parser (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (in_ff),
      .fields(fields)
   );

   hce_encode u_encode (
      .fields(fields),
      .result(result)
   );

   // Result register.
   always_comb begin
      if (advance && in_ff.last) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_ff.last) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // A new result only appears after a last character left the input stage.
   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(in_valid_ff && in_ff.last))
      else $error("result appeared without a last character");

   // Characters that are not last never hold up the input.
   a_no_stall_mid: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !in_ff.last) |-> !req_stall)
      else $error("input stalled on a character that is not last");

   // Any failing status carries a zero word.
   a_error_word_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_OK) |-> (rsp_data.word == 16'h0000))
      else $error("error result with nonzero word");

   // A good word always carries the C-instruction prefix.
   a_ok_prefix: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_OK) |-> (rsp_data.word[15:13] == 3'b111))
      else $error("ok result without 111 prefix");
`endif

endmodule
